// File: rtl/procedure_call_profiler_defines.svh
// Assertion macros shared by the procedure call profiler RTL.
// Depends on nothing; the asserting module supplies clk and arst_n.
`ifndef PROCEDURE_CALL_PROFILER_DEFINES_SVH
`define PROCEDURE_CALL_PROFILER_DEFINES_SVH

// Checked only while out of reset.
`define PCP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PCP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/pcp_pkg.sv
// Package of the procedure call profiler: sizes, codes, transaction types and helpers.
// Depends on nothing; used by the profiler top level.
package pcp_pkg;

	localparam int MODULE_SLOTS = 32;
	localparam int PROC_SLOTS   = 128;
	localparam int STACK_DEPTH  = 128;
	localparam int NAME_BYTES   = 8;

	localparam int ID_W       = $clog2(MODULE_SLOTS);
	localparam int CNT_W      = $clog2(MODULE_SLOTS + 1);
	localparam int PROC_W     = $clog2(PROC_SLOTS);
	localparam int PROF_DEPTH = MODULE_SLOTS * PROC_SLOTS;
	localparam int SLOT_W     = $clog2(PROF_DEPTH);
	localparam int TOP_W      = $clog2(STACK_DEPTH + 1);
	localparam int STK_A_W    = $clog2(STACK_DEPTH);

	localparam logic [1:0] CMD_ENTER = 2'd0;
	localparam logic [1:0] CMD_LEAVE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_FULL      = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] module_name;
		logic [6:0]  proc_number;
		logic [31:0] now_time;
		logic [4:0]  read_module;
	} request_t;

	typedef struct packed {
		logic [4:0]  module_index;
		logic [31:0] call_count;
		logic [31:0] total_time;
		logic [1:0]  error_code;
		logic        dump_request;
	} result_t;

	typedef struct packed {
		logic [31:0] cnt;
		logic [31:0] tim;
	} prof_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PROC_W-1:0] proc;
		logic [31:0]       old_time;
		logic [31:0]       start_time;
	} stack_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_PROF_RD,
		ST_PROF_WR,
		ST_POP_RD,
		ST_POP_WR,
		ST_RD_WAIT
	} state_t;

	// Bounded string compare: bytes after a common zero byte do not matter.
	function automatic logic names_equal(logic [63:0] a, logic [63:0] b);
		logic eq;
		logic ended;
		eq = 1'b1;
		ended = 1'b0;
		for (int i = 0; i < NAME_BYTES && i < 8; i++) begin
			if (!ended) begin
				if (a[8*i +: 8] != b[8*i +: 8]) begin
					eq = 1'b0;
					ended = 1'b1;
				end else if (a[8*i +: 8] == 8'd0) begin
					ended = 1'b1;
				end
			end
		end
		return eq;
	endfunction

	function automatic logic [PROC_W-1:0] proc_slot(logic [6:0] p);
		return (32'(p) >= PROC_SLOTS) ? PROC_W'(PROC_SLOTS - 1) : PROC_W'(p);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_of(logic [ID_W-1:0] id,
		logic [PROC_W-1:0] proc);
		return SLOT_W'(id) * SLOT_W'(PROC_SLOTS) + SLOT_W'(proc);
	endfunction

endpackage

// File: rtl/pcp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pcp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/procedure_call_profiler.sv
// Procedure call profiler: one transaction at a time, busy high while it runs.
// An enter compares the stored names one by one up to a match, takes the next free slot for a
// new name or reports a full table, and first clears the profile when its procedure number
// is 0; a leave pops the call stack and a read fetches one profile entry.
// Throughput: the next transaction may be accepted in the cycle its result strobe shows.
// Reset: a clearing pass over the profile RAM runs with busy high.
`include "procedure_call_profiler_defines.svh"

module procedure_call_profiler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pcp_pkg::request_t request,
	output logic              busy,
	output logic              done,
	output pcp_pkg::result_t  result
);
	import pcp_pkg::*;

	// Control state. All tables live in three RAMs: module names, the profile
	// (call count and accumulated time per module and procedure) and the call stack.
	// The result strobe done lasts one cycle; the receiver cannot stall it.
	state_t             state_q, state_d;
	request_t           req_q;
	logic               pend_q;       // a clearing pass is followed by an enter
	logic [SLOT_W-1:0]  clr_q;
	logic [CNT_W-1:0]   scan_q;
	logic [CNT_W-1:0]   mod_count_q;
	logic [TOP_W-1:0]   top_q;
	logic [ID_W-1:0]    id_q;
	logic [PROC_W-1:0]  proc_q;
	logic [31:0]        pop_time_q;
	result_t            res_q;
	logic               done_q;

	logic accept;
	logic name_match;

	// RAM ports.
	logic               name_we;
	logic [ID_W-1:0]    name_waddr, name_raddr;
	logic [63:0]        name_rdata;
	logic               prof_we;
	logic [SLOT_W-1:0]  prof_waddr, prof_raddr;
	prof_entry_t        prof_wdata, prof_rdata;
	logic               stk_we;
	logic [STK_A_W-1:0] stk_waddr, stk_raddr;
	stack_entry_t       stk_wdata, stk_rdata;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;
	assign name_match = names_equal(name_rdata, req_q.module_name);

	pcp_ram #(.WIDTH(64), .DEPTH(MODULE_SLOTS)) u_name_ram (
		.clk(clk), .we(name_we), .waddr(name_waddr), .wdata(req_q.module_name),
		.raddr(name_raddr), .rdata(name_rdata)
	);

	pcp_ram #(.WIDTH($bits(prof_entry_t)), .DEPTH(PROF_DEPTH)) u_prof_ram (
		.clk(clk), .we(prof_we), .waddr(prof_waddr), .wdata(prof_wdata),
		.raddr(prof_raddr), .rdata(prof_rdata)
	);

	pcp_ram #(.WIDTH($bits(stack_entry_t)), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority case (request.command)
						CMD_ENTER: state_d = (request.proc_number == 7'd0) ? ST_CLEAR : ST_SCAN_RD;
						CMD_LEAVE: state_d = (top_q == '0) ? ST_IDLE : ST_POP_RD;
						CMD_READ:  state_d = (32'(request.read_module) < MODULE_SLOTS) ?
							ST_RD_WAIT : ST_IDLE;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (clr_q == SLOT_W'(PROF_DEPTH - 1)) begin
					state_d = pend_q ? ST_SCAN_RD : ST_IDLE;
				end
			end
			ST_SCAN_RD: begin
				if (scan_q == mod_count_q) begin
					state_d = (32'(mod_count_q) >= MODULE_SLOTS) ? ST_IDLE : ST_PROF_RD;
				end else begin
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: state_d = name_match ? ST_PROF_RD : ST_SCAN_RD;
			ST_PROF_RD:  state_d = ST_PROF_WR;
			ST_PROF_WR:  state_d = ST_IDLE;
			ST_POP_RD:   state_d = ST_POP_WR;
			ST_POP_WR:   state_d = ST_IDLE;
			ST_RD_WAIT:  state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// RAM controls. Only one transaction is in flight and every write lands
	// before the next read of the same entry is issued, so no forwarding is needed.
	always_comb begin
		name_we    = 1'b0;
		name_waddr = ID_W'(mod_count_q);
		name_raddr = ID_W'(scan_q);
		prof_we    = 1'b0;
		prof_waddr = slot_of(id_q, proc_q);
		prof_wdata = '0;
		prof_raddr = slot_of(id_q, proc_q);
		stk_we     = 1'b0;
		stk_waddr  = STK_A_W'(top_q);
		stk_wdata  = '0;
		stk_raddr  = STK_A_W'(top_q - 1'b1);
		unique case (state_q)
			ST_IDLE: begin
				prof_raddr = slot_of(ID_W'(request.read_module), proc_slot(request.proc_number));
			end
			ST_CLEAR: begin
				prof_we    = 1'b1;
				prof_waddr = clr_q;
			end
			ST_SCAN_RD: begin
				// A new name takes the next free slot.
				name_we = (scan_q == mod_count_q) && (32'(mod_count_q) < MODULE_SLOTS);
			end
			ST_PROF_WR: begin
				prof_we        = 1'b1;
				prof_wdata.cnt = prof_rdata.cnt + 32'd1;
				prof_wdata.tim = prof_rdata.tim;
				stk_we         = (32'(top_q) < STACK_DEPTH);
				stk_wdata      = '{id: id_q, proc: proc_q, old_time: prof_rdata.tim,
					start_time: req_q.now_time};
			end
			ST_POP_RD: begin
				prof_raddr = slot_of(stk_rdata.id, stk_rdata.proc);
			end
			ST_POP_WR: begin
				prof_we        = 1'b1;
				prof_wdata.cnt = prof_rdata.cnt;
				prof_wdata.tim = pop_time_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pend_q      <= 1'b0;
			clr_q       <= '0;
			scan_q      <= '0;
			mod_count_q <= '0;
			top_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q <= '0;
						if (request.command == CMD_ENTER && request.proc_number == 7'd0) begin
							mod_count_q <= '0;
							clr_q       <= '0;
							pend_q      <= 1'b1;
						end
						if (request.command == CMD_LEAVE && top_q != '0) begin
							top_q <= top_q - 1'b1;
						end
						if (!(request.command == CMD_ENTER || request.command == CMD_LEAVE &&
							top_q != '0 || request.command == CMD_READ &&
							32'(request.read_module) < MODULE_SLOTS)) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_SCAN_RD: begin
					if (scan_q == mod_count_q) begin
						if (32'(mod_count_q) >= MODULE_SLOTS) begin
							done_q <= 1'b1;
						end else begin
							mod_count_q <= mod_count_q + 1'b1;
						end
					end
				end
				ST_SCAN_CMP: begin
					if (!name_match) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_PROF_WR: begin
					done_q <= 1'b1;
					if (32'(top_q) < STACK_DEPTH) begin
						top_q <= top_q + 1'b1;
					end
				end
				ST_POP_WR:  done_q <= 1'b1;
				ST_RD_WAIT: done_q <= 1'b1;
				default: begin
				end
			endcase
			if (state_q == ST_CLEAR && state_d != ST_CLEAR) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q  <= request;
					proc_q <= proc_slot(request.proc_number);
					res_q  <= '{module_index: (request.command == CMD_READ) ?
							request.read_module : 5'd0,
						call_count: 32'd0, total_time: 32'd0,
						error_code: (request.command == CMD_LEAVE && top_q == '0) ?
							ERR_UNDERFLOW : ERR_OK,
						dump_request: 1'b0};
				end
			end
			ST_SCAN_RD: begin
				if (scan_q == mod_count_q) begin
					id_q <= ID_W'(mod_count_q);
					if (32'(mod_count_q) >= MODULE_SLOTS) begin
						res_q <= '{module_index: 5'd0, call_count: 32'd0, total_time: 32'd0,
							error_code: ERR_FULL, dump_request: 1'b0};
					end
				end
			end
			ST_SCAN_CMP: id_q <= ID_W'(scan_q);
			ST_PROF_WR: begin
				res_q.module_index <= 5'(id_q);
				res_q.call_count   <= prof_rdata.cnt + 32'd1;
				res_q.total_time   <= prof_rdata.tim;
				res_q.error_code   <= (32'(top_q) < STACK_DEPTH) ? ERR_OK : ERR_OVERFLOW;
				res_q.dump_request <= 1'b0;
			end
			ST_POP_RD: begin
				id_q       <= stk_rdata.id;
				proc_q     <= stk_rdata.proc;
				pop_time_q <= stk_rdata.old_time + (req_q.now_time - stk_rdata.start_time);
			end
			ST_POP_WR: begin
				res_q.module_index <= 5'(id_q);
				res_q.call_count   <= prof_rdata.cnt;
				res_q.total_time   <= pop_time_q;
				res_q.error_code   <= ERR_OK;
				res_q.dump_request <= (proc_q == '0);
			end
			ST_RD_WAIT: begin
				res_q.call_count <= prof_rdata.cnt;
				res_q.total_time <= prof_rdata.tim;
			end
			default: begin
			end
		endcase
	end

	`PCP_ASSERT_ALWAYS(a_done_not_busy, !(done && busy), "result strobe while busy")
	`PCP_ASSERT(a_top_bound, 32'(top_q) <= STACK_DEPTH, "stack top beyond depth")
	`PCP_ASSERT(a_count_bound, 32'(mod_count_q) <= MODULE_SLOTS, "module count beyond table")
	`PCP_ASSERT(a_accept_busy, accept |=> (busy || done), "transaction lost after accept")
	`PCP_ASSERT(a_scan_bound, scan_q <= mod_count_q, "name scan past module count")
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the procedure call profiler.
// Drives enter, leave and read transactions and checks each result against a predictor.
// Depends on pcp_pkg and the procedure_call_profiler RTL.
`timescale 1ns / 100ps

module tb;
	import pcp_pkg::*;

	// The scoreboard holds the profiler's state as the predictor sees it and the
	// queue of results still to arrive.
	class profile_scoreboard;
		logic [63:0] names [MODULE_SLOTS];
		int unsigned name_count;
		logic [31:0] counts [PROF_DEPTH];
		logic [31:0] times [PROF_DEPTH];
		int unsigned stk_slot [STACK_DEPTH];
		logic [31:0] stk_old [STACK_DEPTH];
		logic [31:0] stk_start [STACK_DEPTH];
		int unsigned depth;
		result_t pending [$];
		int errors;

		function void clear_tables();
			name_count = 0;
			foreach (counts[i]) begin
				counts[i] = '0;
				times[i] = '0;
			end
		endfunction

		function new();
			clear_tables();
			depth = 0;
			errors = 0;
		endfunction

		function bit same_name(logic [63:0] a, logic [63:0] b);
			for (int i = 0; i < NAME_BYTES; i++) begin
				if (a[8*i +: 8] != b[8*i +: 8]) return 0;
				if (a[8*i +: 8] == 8'd0) return 1;
			end
			return 1;
		endfunction

		// Works out the result of one accepted transaction and updates the state.
		function void note_request(request_t req);
			result_t r;
			int unsigned p, id, slot;
			bit found;
			r = '0;
			found = 0;
			p = (req.proc_number >= PROC_SLOTS) ? PROC_SLOTS - 1 : req.proc_number;
			if (req.command == CMD_ENTER) begin
				if (req.proc_number == 0) clear_tables();
				for (id = 0; id < name_count; id++)
					if (same_name(names[id], req.module_name)) begin
						found = 1;
						break;
					end
				if (!found) begin
					if (name_count >= MODULE_SLOTS) r.error_code = ERR_FULL;
					else begin
						id = name_count;
						names[id] = req.module_name;
						name_count++;
						found = 1;
					end
				end
				if (found) begin
					slot = id * PROC_SLOTS + p;
					counts[slot] += 1;
					r.module_index = 5'(id);
					r.call_count = counts[slot];
					r.total_time = times[slot];
					if (depth >= STACK_DEPTH) r.error_code = ERR_OVERFLOW;
					else begin
						stk_slot[depth] = slot;
						stk_old[depth] = times[slot];
						stk_start[depth] = req.now_time;
						depth++;
					end
				end
			end else if (req.command == CMD_LEAVE) begin
				if (depth == 0) r.error_code = ERR_UNDERFLOW;
				else begin
					depth--;
					slot = stk_slot[depth];
					times[slot] = stk_old[depth] + (req.now_time - stk_start[depth]);
					r.module_index = 5'(slot / PROC_SLOTS);
					r.call_count = counts[slot];
					r.total_time = times[slot];
					r.dump_request = (slot % PROC_SLOTS) == 0;
				end
			end else if (req.command == CMD_READ) begin
				r.module_index = req.read_module;
				slot = req.read_module * PROC_SLOTS + p;
				r.call_count = counts[slot];
				r.total_time = times[slot];
			end
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.module_index !== want.module_index) begin
				$display("%0t: module_index expected %0d got %0d", $time,
					want.module_index, got.module_index);
				errors++;
			end
			if (got.call_count !== want.call_count) begin
				$display("%0t: call_count expected %h got %h", $time,
					want.call_count, got.call_count);
				errors++;
			end
			if (got.total_time !== want.total_time) begin
				$display("%0t: total_time expected %h got %h", $time,
					want.total_time, got.total_time);
				errors++;
			end
			if (got.error_code !== want.error_code) begin
				$display("%0t: error_code expected %0d got %0d", $time,
					want.error_code, got.error_code);
				errors++;
			end
			if (got.dump_request !== want.dump_request) begin
				$display("%0t: dump_request expected %b got %b", $time,
					want.dump_request, got.dump_request);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] CMD_NOP = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	request_t request;
	logic busy;
	logic done;
	result_t result;

	profile_scoreboard sb;
	int idle_pct;
	int quiet_cycles;
	logic [63:0] name_pool [8];

	procedure_call_profiler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results are sampled at the rising edge; an accepted transaction is noted there too.
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
		if (arst_n && start && !busy) sb.note_request(request);
	end

	// The watchdog counts cycles with neither an accepted transaction nor a result.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Presents one transaction from a falling edge and holds it until accepted.
	// Random sender gaps come first, so the idle phase decides the pacing. Busy is
	// stable at the falling edge and tells whether the next rising edge accepts.
	task automatic send(request_t req);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		request <= req;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_fields(logic [1:0] cmd, logic [63:0] name, logic [6:0] proc,
		logic [31:0] now, logic [4:0] rmod);
		request_t req;
		req.command = cmd;
		req.module_name = name;
		req.proc_number = proc;
		req.now_time = now;
		req.read_module = rmod;
		send(req);
	endtask

	function automatic logic [63:0] random_name();
		logic [63:0] n;
		int cut;
		n = {$urandom, $urandom};
		cut = $urandom_range(8);
		// A zero byte in the middle exercises the bounded compare.
		if (cut < 8 && $urandom_range(1)) n[8*cut +: 8] = 8'd0;
		return n;
	endfunction

	// Random traffic: mostly enters and leaves in equal shares, some reads and noise.
	task automatic random_traffic(int items);
		int sel;
		logic [6:0] proc;
		for (int i = 0; i < items; i++) begin
			sel = $urandom_range(99);
			proc = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
			if (sel < 40)
				send_fields(CMD_ENTER, ($urandom_range(4) == 0) ? random_name() :
					name_pool[$urandom_range(7)], proc, $urandom, 5'($urandom));
			else if (sel < 80)
				send_fields(CMD_LEAVE, {$urandom, $urandom}, 7'($urandom), $urandom,
					5'($urandom));
			else if (sel < 96)
				send_fields(CMD_READ, {$urandom, $urandom}, 7'($urandom), $urandom,
					5'($urandom));
			else
				send_fields(CMD_NOP, {$urandom, $urandom}, 7'($urandom), $urandom,
					5'($urandom));
		end
	endtask

	initial begin
		int waited;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		idle_pct = 0;
		quiet_cycles = 0;
		foreach (name_pool[i]) name_pool[i] = random_name();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: underflow on an empty stack, a clearing enter, extremes of
		// the fields, a read of the last module index and the unused command.
		send_fields(CMD_LEAVE, '0, '0, '0, '0);
		send_fields(CMD_ENTER, 64'h0000_0000_0041_4243, 7'd0, 32'd100, '0);
		send_fields(CMD_ENTER, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 32'hFFFF_FFF0, 5'd31);
		send_fields(CMD_ENTER, 64'hFF00_0000_0041_4243, 7'd5, 32'd7, '0);
		send_fields(CMD_LEAVE, '1, '1, 32'd20, '1);
		send_fields(CMD_LEAVE, '0, '0, 32'h0000_0010, '0);
		send_fields(CMD_READ, '0, 7'd127, '0, 5'd1);
		send_fields(CMD_READ, '0, 7'd5, '0, 5'd0);
		send_fields(CMD_READ, '1, 7'd0, '1, 5'd31);
		send_fields(CMD_NOP, '1, '1, '1, '1);
		send_fields(CMD_LEAVE, '0, '0, 32'd500, '0);
		send_fields(CMD_LEAVE, '0, '0, 32'd501, '0);
		// Fill the module table, then one more new name reports a full table.
		for (int i = 0; i < MODULE_SLOTS; i++)
			send_fields(CMD_ENTER, 64'(i + 1) << 8 | 64'h5A, 7'd1, 32'(i), '0);
		send_fields(CMD_ENTER, 64'h0BAD_0BAD_0BAD_0BAD, 7'd3, '0, '0);
		// Push past the stack depth to reach overflow, then drain it fully.
		for (int i = 0; i < STACK_DEPTH; i++)
			send_fields(CMD_ENTER, 64'h5A | (64'(i % 4 + 1) << 8), 7'd2, 32'(i), '0);
		for (int i = 0; i < STACK_DEPTH; i++)
			send_fields(CMD_LEAVE, '0, '0, 32'(1000 + i), '0);

		// Random phases: no sender gaps, heavy gaps, light gaps.
		idle_pct = 0;
		random_traffic(450);
		idle_pct = 82;
		random_traffic(450);
		idle_pct = 20;
		random_traffic(450);
		start <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < WATCHDOG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
